### rtl/pssfp_pkg.sv
// ---------------------------------------------------------------------------
// pssfp_pkg : shared types and constants of the particulate frame parser
// Frame layout constants, result status codes and the record that the
// byte front hands to the frame back.
// ---------------------------------------------------------------------------
package pssfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  localparam logic [4:0] POS_HDR_SECOND = 5'd1;
  localparam logic [4:0] POS_PM1_LOW    = 5'd11;
  localparam logic [4:0] POS_PM25_LOW   = 5'd13;
  localparam logic [4:0] POS_PM10_LOW   = 5'd15;
  localparam logic [4:0] SUM_END        = 5'd30;
  localparam logic [4:0] FRAME_LAST     = 5'd31;

  localparam int          SUM_W             = 13;
  localparam logic [7:0]  ERROR_LIMIT_RESET = 8'd5;
  localparam int          QUEUE_DEPTH_DEF   = 2;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD     = 2'd1,
    ST_CLEARED = 2'd2
  } frame_status_t;

  // One completed frame, as seen by the byte front.
  typedef struct packed {
    logic [15:0]      pm1;
    logic [15:0]      pm25;
    logic [15:0]      pm10;
    logic [15:0]      trailer;
    logic [SUM_W-1:0] sum;
  } frame_rec_t;

  // One result item.
  typedef struct packed {
    logic [7:0]    errors_now;
    frame_status_t frame_status;
    logic [15:0]   pm10_value;
    logic [15:0]   pm25_value;
    logic [15:0]   pm1_value;
  } frame_result_t;

endpackage

### rtl/pssfp_front.sv
// ---------------------------------------------------------------------------
// pssfp_front : byte front of the frame parser
// Tracks the byte position, checks the header, keeps the running sum and
// captures the PM words; emits one record per completed frame.
// ---------------------------------------------------------------------------
module pssfp_front
  import pssfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] rx_byte,
  output logic       rec_valid,
  input  logic       rec_ready,
  output frame_rec_t rec
);

  logic [4:0]       byte_position;
  logic [7:0]       header_first;
  logic [SUM_W-1:0] running_sum;
  logic [7:0]       high_byte_hold;
  logic [15:0]      pm1_capture;
  logic [15:0]      pm25_capture;
  logic [15:0]      pm10_capture;

  logic [15:0]      word;
  logic             take;
  logic             bad_header;

  assign word       = {high_byte_hold, rx_byte};
  assign byte_ready = (byte_position != FRAME_LAST) || rec_ready;
  assign take       = byte_valid && byte_ready;
  assign bad_header = (byte_position == POS_HDR_SECOND) &&
                      ((header_first != HDR_FIRST) || (rx_byte != HDR_SECOND));

  assign rec_valid    = byte_valid && (byte_position == FRAME_LAST);
  assign rec.pm1      = pm1_capture;
  assign rec.pm25     = pm25_capture;
  assign rec.pm10     = pm10_capture;
  assign rec.trailer  = word;
  assign rec.sum      = running_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      header_first   <= '0;
      running_sum    <= '0;
      high_byte_hold <= '0;
      pm1_capture    <= '0;
      pm25_capture   <= '0;
      pm10_capture   <= '0;
    end else if (take) begin
      if (byte_position == '0) begin
        header_first   <= rx_byte;
        running_sum    <= {{(SUM_W-8){1'b0}}, rx_byte};
        high_byte_hold <= rx_byte;
        byte_position  <= 5'd1;
      end else if (bad_header) begin
        // drop both header bytes and hunt again
        byte_position <= '0;
        running_sum   <= '0;
      end else begin
        if (byte_position < SUM_END) begin
          running_sum <= running_sum + {{(SUM_W-8){1'b0}}, rx_byte};
        end
        if (!byte_position[0]) begin
          high_byte_hold <= rx_byte;
        end else if (byte_position == POS_PM1_LOW) begin
          pm1_capture <= word;
        end else if (byte_position == POS_PM25_LOW) begin
          pm25_capture <= word;
        end else if (byte_position == POS_PM10_LOW) begin
          pm10_capture <= word;
        end
        if (byte_position == FRAME_LAST) begin
          byte_position <= '0;
          running_sum   <= '0;
        end else begin
          byte_position <= byte_position + 5'd1;
        end
      end
    end
  end

endmodule

### rtl/pssfp_queue.sv
// ---------------------------------------------------------------------------
// pssfp_queue : short frame record queue
// Register FIFO between the byte front and the frame back.
// ---------------------------------------------------------------------------
module pssfp_queue
  import pssfp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  frame_rec_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output frame_rec_t pop_data,
  output logic       full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

  frame_rec_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == DEPTH_C);
  assign push_ready = !full;
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/pssfp_back.sv
// ---------------------------------------------------------------------------
// pssfp_back : frame back of the parser
// Checks the trailer against the sum, keeps the error count and the
// published values, and holds the result in an output register.
// ---------------------------------------------------------------------------
module pssfp_back
  import pssfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    error_limit,
  input  logic          rec_valid,
  output logic          rec_ready,
  input  frame_rec_t    rec,
  output logic          res_valid,
  input  logic          res_ready,
  output frame_result_t res
);

  logic [15:0]   pm1_published;
  logic [15:0]   pm25_published;
  logic [15:0]   pm10_published;
  logic [7:0]    error_count;

  logic          good;
  logic          at_limit;
  logic [15:0]   pm1_next;
  logic [15:0]   pm25_next;
  logic [15:0]   pm10_next;
  logic [7:0]    error_count_next;
  frame_status_t status_next;
  logic          take;

  assign rec_ready = !res_valid || res_ready;
  assign take      = rec_valid && rec_ready;
  assign good      = (rec.trailer != 16'd0) &&
                     (rec.trailer == {{(16-SUM_W){1'b0}}, rec.sum});
  assign at_limit  = (error_count >= error_limit);

  always_comb begin
    pm1_next         = pm1_published;
    pm25_next        = pm25_published;
    pm10_next        = pm10_published;
    error_count_next = error_count + 8'd1;
    status_next      = ST_BAD;
    if (good) begin
      pm1_next         = rec.pm1;
      pm25_next        = rec.pm25;
      pm10_next        = rec.pm10;
      error_count_next = '0;
      status_next      = ST_GOOD;
    end else if (at_limit) begin
      pm1_next         = '0;
      pm25_next        = '0;
      pm10_next        = '0;
      error_count_next = '0;
      status_next      = ST_CLEARED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pm1_published  <= '0;
      pm25_published <= '0;
      pm10_published <= '0;
      error_count    <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (take) begin
        pm1_published  <= pm1_next;
        pm25_published <= pm25_next;
        pm10_published <= pm10_next;
        error_count    <= error_count_next;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.pm1_value    <= pm1_next;
      res.pm25_value   <= pm25_next;
      res.pm10_value   <= pm10_next;
      res.frame_status <= status_next;
      res.errors_now   <= error_count_next;
    end
  end

endmodule

### rtl/particle_sensor_frame_parser_unit.sv
// ---------------------------------------------------------------------------
// particle_sensor_frame_parser_unit : 32-byte particulate sensor frame parser
// Takes received serial bytes, frames them on the 0x42 0x4D header, checks
// the 16-bit trailer against the byte sum and reports PM1, PM2.5 and PM10.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  s_*      | in        | s_tvalid / s_tready    | rx_byte, one per request
//  m_*      | out       | m_tvalid / m_tready    | one result per full frame
//  cfg_*    | in        | cfg_valid / cfg_ready  | error_limit write
//
//  A byte is taken every cycle; s_tready drops only when the last byte of a
//  frame arrives and the frame queue is full.
//  A frame's result reaches m_tvalid through the queue register and then
//  the back's output register.
//  Reset clears position, sum, error count and published values, and sets
//  error_limit to 5. No clearing pass: the block is ready right after reset.
//  A stalled m_tready holds the result; the front keeps taking bytes until
//  the queue fills.
// ---------------------------------------------------------------------------
module particle_sensor_frame_parser_unit
  import pssfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // frame results out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] pm1_value, [31:16] pm25_value,
                                 // [47:32] pm10_value, [49:48] frame_status,
                                 // [57:50] errors_now, [63:58] zero
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // error_limit
);

  logic [7:0]    error_limit;
  frame_rec_t    front_rec;
  logic          front_rec_valid;
  logic          front_rec_ready;
  frame_rec_t    back_rec;
  logic          back_rec_valid;
  logic          back_rec_ready;
  logic          queue_full;
  frame_result_t result;

  // Configuration: always ready; hold the limit until the next write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit <= ERROR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      error_limit <= cfg_data;
    end
  end

  // Front: position, header check, sum and PM word capture.
  pssfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .rx_byte    (s_tdata),
    .rec_valid  (front_rec_valid),
    .rec_ready  (front_rec_ready),
    .rec        (front_rec)
  );

  // Queue: decouple the front from a stalled result channel.
  pssfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_rec_valid),
    .push_ready (front_rec_ready),
    .push_data  (front_rec),
    .pop_valid  (back_rec_valid),
    .pop_ready  (back_rec_ready),
    .pop_data   (back_rec),
    .full       (queue_full)
  );

  // Back: verdict, error count, published values, output register.
  pssfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .error_limit (error_limit),
    .rec_valid   (back_rec_valid),
    .rec_ready   (back_rec_ready),
    .rec         (back_rec),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res         (result)
  );

  // Pack the result, last field in the lowest bits, zero-pad to 64 bits.
  assign m_tdata = {6'd0, result};

  // A good frame always leaves the error count at zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (result.frame_status == ST_GOOD) |-> result.errors_now == 8'd0)
    else $error("good frame reported with non-zero error count");

  // Hitting the limit clears every published value and the count.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (result.frame_status == ST_CLEARED) |->
      (result.pm1_value == 16'd0) && (result.pm25_value == 16'd0) &&
      (result.pm10_value == 16'd0) && (result.errors_now == 8'd0))
    else $error("cleared frame reported with non-zero values");

  // The byte side only stalls on a frame end with the queue full.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> queue_full)
    else $error("byte stream stalled with queue space left");

  // A frame record leaving the front is taken by the queue the same cycle
  // whenever the front accepts the last byte.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && front_rec_valid |-> front_rec_ready)
    else $error("last byte accepted but frame record dropped");

endmodule

### bench/pssfp_result_checker.sv
// ---------------------------------------------------------------------------
// pssfp_result_checker : frame result scoreboard for the particulate parser
// Watches the byte, result and configuration channels, rebuilds each frame's
// outcome from the accepted bytes and compares every result field with it.
// ---------------------------------------------------------------------------
module pssfp_result_checker
  import pssfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outstanding
);

  // Frame parser state as the block should hold it.
  logic [7:0]       err_limit;
  logic [4:0]       frame_pos;
  logic [7:0]       hdr_byte;
  logic [SUM_W-1:0] byte_sum;
  logic [7:0]       hold_byte;
  logic [15:0]      cap_pm1, cap_pm25, cap_pm10;
  logic [15:0]      pub_pm1, pub_pm25, pub_pm10;
  logic [7:0]       err_count;

  frame_result_t expected_results[$];
  int            result_index;

  task automatic report_mismatch(input string msg);
    $display("mismatch: result %0d: %s", result_index, msg);
    mismatches++;
  endtask

  // Advance the parser by one byte; done is set on the last byte of a frame.
  task automatic parse_rx_byte(input logic [7:0] rx, output bit done,
                               output frame_result_t res);
    logic [15:0] word;
    word = {hold_byte, rx};
    done = 1'b0;
    res  = '0;
    if (frame_pos == 5'd0) begin
      hdr_byte  = rx;
      byte_sum  = SUM_W'(rx);
      hold_byte = rx;
      frame_pos = 5'd1;
    end else if (frame_pos == POS_HDR_SECOND &&
                 (hdr_byte != HDR_FIRST || rx != HDR_SECOND)) begin
      frame_pos = 5'd0;
      byte_sum  = '0;
    end else begin
      if (frame_pos < SUM_END)
        byte_sum = byte_sum + SUM_W'(rx);
      if (!frame_pos[0])
        hold_byte = rx;
      else if (frame_pos == POS_PM1_LOW)
        cap_pm1 = word;
      else if (frame_pos == POS_PM25_LOW)
        cap_pm25 = word;
      else if (frame_pos == POS_PM10_LOW)
        cap_pm10 = word;

      if (frame_pos != FRAME_LAST) begin
        frame_pos = frame_pos + 5'd1;
      end else begin
        // A zero trailer never passes, whatever the sum.
        if (word != 16'd0 && word == 16'(byte_sum)) begin
          err_count = 8'd0;
          pub_pm1   = cap_pm1;
          pub_pm25  = cap_pm25;
          pub_pm10  = cap_pm10;
          res.frame_status = ST_GOOD;
        end else if (err_count >= err_limit) begin
          err_count = 8'd0;
          cap_pm1   = '0;
          cap_pm25  = '0;
          cap_pm10  = '0;
          pub_pm1   = '0;
          pub_pm25  = '0;
          pub_pm10  = '0;
          res.frame_status = ST_CLEARED;
        end else begin
          err_count = err_count + 8'd1;
          res.frame_status = ST_BAD;
        end
        frame_pos = 5'd0;
        byte_sum  = '0;
        res.pm1_value  = pub_pm1;
        res.pm25_value = pub_pm25;
        res.pm10_value = pub_pm10;
        res.errors_now = err_count;
        done = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    frame_result_t want;
    frame_result_t got;
    bit            done;
    if (rst) begin
      err_limit = ERROR_LIMIT_RESET;
      frame_pos = '0;
      hdr_byte  = '0;
      byte_sum  = '0;
      hold_byte = '0;
      cap_pm1   = '0;
      cap_pm25  = '0;
      cap_pm10  = '0;
      pub_pm1   = '0;
      pub_pm25  = '0;
      pub_pm10  = '0;
      err_count = '0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(frame_result_t)-1:0];
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no frame pending");
        end else begin
          want = expected_results.pop_front();
          if (got.pm1_value != want.pm1_value)
            report_mismatch($sformatf("pm1_value got %h want %h",
                                      got.pm1_value, want.pm1_value));
          if (got.pm25_value != want.pm25_value)
            report_mismatch($sformatf("pm25_value got %h want %h",
                                      got.pm25_value, want.pm25_value));
          if (got.pm10_value != want.pm10_value)
            report_mismatch($sformatf("pm10_value got %h want %h",
                                      got.pm10_value, want.pm10_value));
          if (got.frame_status != want.frame_status)
            report_mismatch($sformatf("frame_status got %0d want %0d",
                                      got.frame_status, want.frame_status));
          if (got.errors_now != want.errors_now)
            report_mismatch($sformatf("errors_now got %0d want %0d",
                                      got.errors_now, want.errors_now));
        end
        result_index++;
      end
      if (cfg_valid && cfg_ready)
        err_limit = cfg_data;
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata, done, want);
        if (done)
          expected_results.push_back(want);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

### bench/particle_sensor_frame_parser_unit_test.sv
// ---------------------------------------------------------------------------
// particle_sensor_frame_parser_unit_test : bench top of the frame parser
// Drives serial bytes, result back-pressure and error_limit writes; a
// separate scoreboard predicts and checks every frame result.
// ---------------------------------------------------------------------------
module particle_sensor_frame_parser_unit_test;
  import pssfp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  // Allow a margin after the last result before touching the register.
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_BYTES  = 850;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_ZERO_TRAILER,
    FRAME_WIDE_TRAILER
  } frame_kind_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = 8'd0;

  int mismatches;
  int outstanding;
  int cycle_count;
  int bytes_sent;
  bit no_idle;

  particle_sensor_frame_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pssfp_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the stream ever stalls for good.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Present one byte request after a drawn gap and hold it until taken.
  // A zero gap keeps tvalid high straight through, so it is never lowered
  // and raised in the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Mostly random words, with the two extremes drawn often.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Build one 32-byte frame and send it. A negative fill means random
  // filler bytes; otherwise every free byte takes the fill value.
  task automatic send_frame(input frame_kind_t kind, input logic [15:0] pm1,
                            input logic [15:0] pm25, input logic [15:0] pm10,
                            input int fill);
    logic [7:0]  frame [32];
    logic [15:0] sum;
    logic [15:0] trailer;
    int          i;
    for (i = 0; i < 30; i++)
      frame[i] = (fill < 0) ? 8'($urandom) : fill[7:0];
    frame[0]  = HDR_FIRST;
    frame[1]  = HDR_SECOND;
    frame[10] = pm1[15:8];
    frame[11] = pm1[7:0];
    frame[12] = pm25[15:8];
    frame[13] = pm25[7:0];
    frame[14] = pm10[15:8];
    frame[15] = pm10[7:0];
    sum = 16'd0;
    for (i = 0; i < 30; i++)
      sum = sum + 16'(frame[i]);
    case (kind)
      FRAME_GOOD:         trailer = sum;
      // One flipped bit in the low 13 bits always breaks the match; should
      // it land on zero, the frame fails all the same.
      FRAME_BAD_SUM:      trailer = sum ^ (16'd1 << $urandom_range(0, 12));
      FRAME_ZERO_TRAILER: trailer = 16'd0;
      // Low 13 bits match the sum; the bits above must still fail it.
      default:            trailer = sum + 16'h2000 * 16'($urandom_range(1, 7));
    endcase
    frame[30] = trailer[15:8];
    frame[31] = trailer[7:0];
    for (i = 0; i < 32; i++)
      send_byte(frame[i]);
  endtask

  // Write error_limit once the parser has no frame in flight.
  task automatic write_limit(input logic [7:0] limit);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: stall for a drawn number of cycles before each request,
  // then hold tready high until a result is taken.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int          start_bytes;
    int          pick;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  limit;
    frame_kind_t kind;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset limit of five.
    // Good frames at both ends of the byte range.
    send_frame(FRAME_GOOD, 16'h0000, 16'h0000, 16'h0000, 0);
    send_frame(FRAME_GOOD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255);
    // Broken headers: wrong second byte, wrong first byte, neither right.
    send_byte(HDR_FIRST);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(HDR_SECOND);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // Bad frames counted up to the limit, then one more clears the values.
    send_frame(FRAME_ZERO_TRAILER, 16'h1234, 16'h5678, 16'h9ABC, -1);
    send_frame(FRAME_WIDE_TRAILER, pick_word(), pick_word(), pick_word(), -1);
    repeat (3)
      send_frame(FRAME_BAD_SUM, pick_word(), pick_word(), pick_word(), -1);
    send_frame(FRAME_BAD_SUM, pick_word(), pick_word(), pick_word(), -1);
    send_frame(FRAME_GOOD, 16'h00A5, 16'h5A00, 16'h8001, -1);
    // A zero limit clears on every bad frame.
    write_limit(8'd0);
    send_frame(FRAME_BAD_SUM, pick_word(), pick_word(), pick_word(), -1);
    send_frame(FRAME_GOOD, pick_word(), pick_word(), pick_word(), -1);
    // The top limit only ever counts.
    write_limit(8'd255);
    send_frame(FRAME_BAD_SUM, pick_word(), pick_word(), pick_word(), -1);
    send_frame(FRAME_ZERO_TRAILER, pick_word(), pick_word(), pick_word(), -1);

    // Random part: phases of frames, noise and broken headers, each under a
    // fresh limit. Noise comes in pairs that are never a header, so the
    // parser stays aligned with the frames that follow.
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 5))
        0:       limit = 8'd0;
        1:       limit = 8'd255;
        2:       limit = 8'd1;
        5:       limit = 8'($urandom);
        default: limit = 8'($urandom_range(0, 8));
      endcase
      write_limit(limit);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 10)) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          case ($urandom_range(0, 9))
            5, 6:    kind = FRAME_BAD_SUM;
            7:       kind = FRAME_ZERO_TRAILER;
            8:       kind = FRAME_WIDE_TRAILER;
            default: kind = FRAME_GOOD;
          endcase
          send_frame(kind, pick_word(), pick_word(), pick_word(), -1);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 3)) begin
            a = 8'($urandom);
            b = 8'($urandom);
            if (a == HDR_FIRST && b == HDR_SECOND)
              b = 8'h00;
            send_byte(a);
            send_byte(b);
          end
        end else begin
          if ($urandom_range(0, 1) == 0) begin
            a = HDR_FIRST;
            b = 8'($urandom);
            if (b == HDR_SECOND)
              b = ~b;
          end else begin
            a = 8'($urandom);
            if (a == HDR_FIRST)
              a = ~a;
            b = HDR_SECOND;
          end
          send_byte(a);
          send_byte(b);
        end
      end
    end

    // Drop the byte stream, drain every pending result, then give the verdict.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### particle_sensor_frame_parser_unit.f
rtl/pssfp_pkg.sv
rtl/pssfp_front.sv
rtl/pssfp_queue.sv
rtl/pssfp_back.sv
rtl/particle_sensor_frame_parser_unit.sv
bench/pssfp_result_checker.sv
bench/particle_sensor_frame_parser_unit_test.sv
